/* hdl/ack_dedup_table_core_assert.svh */
// Assertion macros shared by the ack dedup table RTL.
`ifndef ACK_DEDUP_TABLE_CORE_ASSERT_SVH
`define ACK_DEDUP_TABLE_CORE_ASSERT_SVH

// Check that post holds in the same cycle as pre.
`define ADT_ASSERT_SAME(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error(msg);

// Check that post holds in the cycle after pre.
`define ADT_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);

`endif

/* hdl/adt_pkg.sv */
// Shared constants and types for the ack dedup table.
`timescale 1ns / 1ps

package adt_pkg;

  localparam int DEPTH  = 20;
  localparam int ID_W   = 16;
  localparam int SRC_W  = 16;
  localparam int MODE_W = 8;
  localparam int IDX_W  = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int LOC_W  = 5;
  localparam int HIDX_W = 5;
  localparam int OCC_W  = 5;

  localparam int IN_DATA_W  = 48;
  localparam int IN_USER_W  = 2;
  localparam int OUT_DATA_W = 16;

  localparam int ID_LSB   = 0;
  localparam int SRC_LSB  = 16;
  localparam int MODE_LSB = 32;
  localparam int LOC_LSB  = 40;

  localparam logic [1:0] REQ_ADD    = 2'd0;
  localparam logic [1:0] REQ_QUERY  = 2'd1;
  localparam logic [1:0] REQ_REMOVE = 2'd2;

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [SRC_W-1:0]  src;
    logic [MODE_W-1:0] mode;
  } entry_t;

  typedef struct packed {
    logic             vld;
    logic             found;
    logic [IDX_W-1:0] idx;
  } probe_t;

  typedef struct packed {
    logic             shift_en;
    logic [IDX_W-1:0] shift_pos;
    entry_t           shift_tail;
    logic             write_en;
    logic [IDX_W-1:0] write_idx;
    entry_t           key;
    logic [CNT_W-1:0] count;
  } cell_ctl_t;

endpackage

/* hdl/adt_cell.sv */
// One table slot: holds an entry, shifts down from its neighbor or takes a written key, and passes the probe token.
`timescale 1ns / 1ps

module adt_cell (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic [adt_pkg::IDX_W-1:0] cell_idx,
  input  adt_pkg::cell_ctl_t      ctl,
  input  adt_pkg::entry_t         up_entry,
  output adt_pkg::entry_t         entry_out,
  input  adt_pkg::probe_t         probe_in,
  output adt_pkg::probe_t         probe_out
);

  adt_pkg::entry_t entry_r;
  adt_pkg::entry_t entry_nxt;
  adt_pkg::probe_t probe_r;
  adt_pkg::probe_t probe_nxt;
  logic            hit_here;

  assign hit_here = (adt_pkg::CNT_W'(cell_idx) < ctl.count) && (entry_r == ctl.key);

  always_comb begin
    probe_nxt = probe_in;
    if (probe_in.vld && !probe_in.found && hit_here) begin
      probe_nxt.found = 1'b1;
      probe_nxt.idx   = cell_idx;
    end
  end

  always_comb begin
    entry_nxt = entry_r;
    if (ctl.shift_en && (cell_idx >= ctl.shift_pos)) begin
      entry_nxt = up_entry;
    end else if (ctl.write_en && (cell_idx == ctl.write_idx)) begin
      entry_nxt = ctl.key;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_r <= '0;
      probe_r <= '0;
    end else begin
      entry_r <= entry_nxt;
      probe_r <= probe_nxt;
    end
  end

  assign entry_out = entry_r;
  assign probe_out = probe_r;

endmodule

/* hdl/ack_dedup_table_core.sv */
// Top level of the ack dedup table: request sequencer and the row of slot cells.
`timescale 1ns / 1ps
//
//  channel | dir | handshake          | payload
//  in      | in  | in_tvalid/tready   | tuser: req_type; tdata: id, source, mode, location
//  out     | out | out_tvalid/tready  | tdata: accepted, hit, hit_index, occupancy
//
//  Add and query with nonzero keys run a probe pass (the probe token walks one
//  cell per cycle) before the apply step.
//  Remove, unused codes and empty keys skip the probe and go straight to apply.
//  Reset clears every slot and the count at once; no clearing pass.
//  A result waits in the output register; a new beat is taken meanwhile, and the
//  sequencer holds in its apply step only while that register is still full.

module ack_dedup_table_core (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // [1:0] req_type
  input  logic [adt_pkg::IN_USER_W-1:0]    in_tuser,
  // [15:0] ack_id, [31:16] source_addr, [39:32] ack_mode, [44:40] location, [47:45] zero
  input  logic [adt_pkg::IN_DATA_W-1:0]    in_tdata,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // [0] accepted, [1] hit, [6:2] hit_index, [11:7] occupancy, [15:12] zero
  output logic [adt_pkg::OUT_DATA_W-1:0]   out_tdata
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_PROBE,
    S_APPLY
  } state_t;

  state_t                       state_r;
  logic [1:0]                   req_r;
  adt_pkg::entry_t              key_r;
  logic                         keys_ok_r;
  logic [adt_pkg::LOC_W-1:0]    loc_r;
  logic [adt_pkg::CNT_W-1:0]    count_r;
  logic [adt_pkg::CNT_W-1:0]    count_nxt;
  logic                         found_r;
  logic [adt_pkg::IDX_W-1:0]    found_idx_r;
  logic                         launch_r;
  logic                         out_valid_r;
  logic [adt_pkg::OUT_DATA_W-1:0] out_data_r;

  adt_pkg::entry_t              in_key;
  logic                         in_keys_ok;
  logic                         in_beat;
  logic                         apply_go;
  adt_pkg::cell_ctl_t           ctl;
  adt_pkg::probe_t              probe_head;
  adt_pkg::probe_t              probe_tail;
  logic                         res_acc;
  logic                         res_hit;
  logic [adt_pkg::IDX_W-1:0]    res_idx;
  logic                         do_shift;
  logic [adt_pkg::IDX_W-1:0]    shift_pos;
  adt_pkg::entry_t              shift_tail;
  logic                         do_write;
  logic                         probe_end;
  logic                         add_go;

  adt_pkg::entry_t              cell_entry [adt_pkg::DEPTH];
  adt_pkg::entry_t              cell_up    [adt_pkg::DEPTH];
  adt_pkg::probe_t              cell_probe [adt_pkg::DEPTH + 1];
  logic [adt_pkg::DEPTH-1:0]    probe_vld;

  assign in_key.id   = in_tdata[adt_pkg::ID_LSB   +: adt_pkg::ID_W];
  assign in_key.src  = in_tdata[adt_pkg::SRC_LSB  +: adt_pkg::SRC_W];
  assign in_key.mode = in_tdata[adt_pkg::MODE_LSB +: adt_pkg::MODE_W];
  assign in_keys_ok  = (in_key.id != '0) && (in_key.src != '0) && (in_key.mode != '0);

  assign in_tready = (state_r == S_IDLE);
  assign in_beat   = in_tvalid && in_tready;
  assign apply_go  = (state_r == S_APPLY) && (!out_valid_r || out_tready);

  always_comb begin
    res_acc    = 1'b0;
    res_hit    = 1'b0;
    res_idx    = '0;
    do_shift   = 1'b0;
    shift_pos  = '0;
    shift_tail = '0;
    do_write   = 1'b0;
    count_nxt  = count_r;
    unique case (req_r)
      adt_pkg::REQ_ADD: begin
        if (keys_ok_r) begin
          res_acc = 1'b1;
          if (found_r) begin
            res_hit = 1'b1;
            res_idx = found_idx_r;
          end else if (count_r == adt_pkg::CNT_W'(adt_pkg::DEPTH)) begin
            do_shift   = 1'b1;
            shift_tail = key_r;
            res_idx    = adt_pkg::IDX_W'(adt_pkg::DEPTH - 1);
          end else begin
            do_write  = 1'b1;
            res_idx   = count_r[adt_pkg::IDX_W-1:0];
            count_nxt = count_r + 1'b1;
          end
        end
      end
      adt_pkg::REQ_QUERY: begin
        if (keys_ok_r && found_r) begin
          res_acc = 1'b1;
          res_hit = 1'b1;
          res_idx = found_idx_r;
        end
      end
      adt_pkg::REQ_REMOVE: begin
        if (loc_r < adt_pkg::LOC_W'(count_r)) begin
          do_shift  = 1'b1;
          shift_pos = loc_r[adt_pkg::IDX_W-1:0];
          count_nxt = count_r - 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  assign ctl.shift_en   = apply_go && do_shift;
  assign ctl.shift_pos  = shift_pos;
  assign ctl.shift_tail = shift_tail;
  assign ctl.write_en   = apply_go && do_write;
  assign ctl.write_idx  = count_r[adt_pkg::IDX_W-1:0];
  assign ctl.key        = key_r;
  assign ctl.count      = count_r;

  assign probe_head.vld   = launch_r;
  assign probe_head.found = 1'b0;
  assign probe_head.idx   = '0;
  assign cell_probe[0]    = probe_head;
  assign probe_tail       = cell_probe[adt_pkg::DEPTH];

  for (genvar i = 0; i < adt_pkg::DEPTH; i++) begin : g_cell
    if (i == adt_pkg::DEPTH - 1) begin : g_top
      assign cell_up[i] = ctl.shift_tail;
    end else begin : g_mid
      assign cell_up[i] = cell_entry[i + 1];
    end
    assign probe_vld[i] = cell_probe[i + 1].vld;

    adt_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .cell_idx  (adt_pkg::IDX_W'(i)),
      .ctl       (ctl),
      .up_entry  (cell_up[i]),
      .entry_out (cell_entry[i]),
      .probe_in  (cell_probe[i]),
      .probe_out (cell_probe[i + 1])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      launch_r    <= 1'b0;
      out_valid_r <= 1'b0;
      found_r     <= 1'b0;
    end else begin
      launch_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (in_beat) begin
            req_r     <= in_tuser;
            key_r     <= in_key;
            keys_ok_r <= in_keys_ok;
            loc_r     <= in_tdata[adt_pkg::LOC_LSB +: adt_pkg::LOC_W];
            found_r   <= 1'b0;
            if (in_keys_ok &&
                ((in_tuser == adt_pkg::REQ_ADD) || (in_tuser == adt_pkg::REQ_QUERY))) begin
              launch_r <= 1'b1;
              state_r  <= S_PROBE;
            end else begin
              state_r <= S_APPLY;
            end
          end
        end
        S_PROBE: begin
          if (probe_tail.vld) begin
            found_r     <= probe_tail.found;
            found_idx_r <= probe_tail.idx;
            state_r     <= S_APPLY;
          end
        end
        S_APPLY: begin
          if (apply_go) begin
            count_r    <= count_nxt;
            out_data_r <= {4'b0000, adt_pkg::OCC_W'(count_nxt),
                           adt_pkg::HIDX_W'(res_idx), res_hit, res_acc};
            state_r    <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
      if (apply_go) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  assign probe_end = (state_r == S_PROBE) && probe_tail.vld;
  assign add_go    = apply_go && (req_r == adt_pkg::REQ_ADD) && keys_ok_r;

`include "ack_dedup_table_core_assert.svh"

  `ADT_ASSERT_SAME(a_count_bound, 1'b1, count_r <= adt_pkg::CNT_W'(adt_pkg::DEPTH), "count high")
  `ADT_ASSERT_SAME(a_one_token, 1'b1, $countones(probe_vld) <= 1, "several probe tokens")
  `ADT_ASSERT_NEXT(a_probe_done, probe_end, state_r == S_APPLY, "probe end missed")
  `ADT_ASSERT_NEXT(a_add_fills, add_go, count_r != '0, "add left table empty")

endmodule
